// ----- sv/sct_pkg.sv -----
// ----------------------------------------------------------------------------
// sct_pkg
// Shared types, constants and helper functions for the source character
// tokenizer.
// ----------------------------------------------------------------------------
package sct_pkg;

    localparam int POSITION_BITS = 16;
    localparam int LENGTH_BITS   = 8;
    localparam int PREFIX_BYTES  = 5;
    localparam int PREFIX_BITS   = 8 * PREFIX_BYTES;
    localparam int FIFO_DEPTH    = 4;

    typedef logic [POSITION_BITS-1:0] pos_t;
    typedef logic [LENGTH_BITS-1:0]   len_t;
    typedef logic [PREFIX_BITS-1:0]   prefix_t;

    localparam pos_t POS_MAX = '1;
    localparam pos_t POS_ONE = pos_t'(1);
    localparam len_t LEN_MAX = '1;

    localparam logic [7:0] CH_NEWLINE    = 8'h0A;
    localparam logic [7:0] CH_SPACE      = 8'h20;
    localparam logic [7:0] CH_DOT        = 8'h2E;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;

    // Keyword spellings, first character in the low byte.
    localparam prefix_t WORD_LET   = prefix_t'(40'h00_0074_656c);
    localparam prefix_t WORD_FUN   = prefix_t'(40'h00_006e_7566);
    localparam prefix_t WORD_IF    = prefix_t'(40'h00_0000_6669);
    localparam prefix_t WORD_ELSE  = prefix_t'(40'h00_6573_6c65);
    localparam prefix_t WORD_FOR   = prefix_t'(40'h00_0072_6f66);
    localparam prefix_t WORD_WHILE = prefix_t'(40'h65_6c69_6877);
    localparam prefix_t WORD_TRUE  = prefix_t'(40'h00_6575_7274);
    localparam prefix_t WORD_FALSE = prefix_t'(40'h65_736c_6166);

    typedef enum logic [3:0] {
        KIND_NUMBER  = 4'd0,
        KIND_IDENT   = 4'd1,
        KIND_BOOL    = 4'd2,
        KIND_LET     = 4'd3,
        KIND_FUN     = 4'd4,
        KIND_IF      = 4'd5,
        KIND_ELSE    = 4'd6,
        KIND_FOR     = 4'd7,
        KIND_WHILE   = 4'd8,
        KIND_BADCHAR = 4'd9,
        KIND_TWODOTS = 4'd10
    } kind_t;

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_NUMBER = 2'd1,
        MODE_IDENT  = 2'd2,
        MODE_FAILED = 2'd3
    } mode_t;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       end_of_input;
    } in_word_t;

    typedef struct packed {
        logic [3:0] token_kind;
        pos_t       start_line;
        pos_t       start_column;
        len_t       token_length;
        logic       last_of_run;
    } out_word_t;

    typedef struct packed {
        logic    valid;
        kind_t   kind;
        pos_t    line;
        pos_t    column;
        len_t    length;
        prefix_t prefix;
    } slot_t;

    typedef struct packed {
        slot_t first;
        slot_t second;
    } entry_t;

    function automatic slot_t make_slot(kind_t kind, pos_t line, pos_t column,
                                        len_t length, prefix_t prefix);
        slot_t s;
        s.valid  = 1'b1;
        s.kind   = kind;
        s.line   = line;
        s.column = column;
        s.length = length;
        s.prefix = prefix;
        return s;
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_letter(logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    function automatic kind_t word_kind(len_t length, prefix_t prefix);
        kind_t k;
        k = KIND_IDENT;
        if (length == len_t'(3) && prefix == WORD_LET) begin
            k = KIND_LET;
        end else if (length == len_t'(3) && prefix == WORD_FUN) begin
            k = KIND_FUN;
        end else if (length == len_t'(2) && prefix == WORD_IF) begin
            k = KIND_IF;
        end else if (length == len_t'(4) && prefix == WORD_ELSE) begin
            k = KIND_ELSE;
        end else if (length == len_t'(3) && prefix == WORD_FOR) begin
            k = KIND_FOR;
        end else if (length == len_t'(5) && prefix == WORD_WHILE) begin
            k = KIND_WHILE;
        end else if (length == len_t'(4) && prefix == WORD_TRUE) begin
            k = KIND_BOOL;
        end else if (length == len_t'(5) && prefix == WORD_FALSE) begin
            k = KIND_BOOL;
        end
        return k;
    endfunction

endpackage

// ----- sv/source_char_tokenizer.sv -----
// Path: the results of an accepted word are written into the queue, then loaded from its head
// into the output register that drives m_valid and m_data.
// Throughput: one source byte per cycle while the queue is not full; the output register
// issues one result per cycle if m_ready allows; a four-entry queue holds two-result bytes.
// Reset: synchronous, active-low aresetn returns the scanner to idle at line 1, column 1
// and empties the queue and the output register.
// ----------------------------------------------------------------------------
// source_char_tokenizer
// Character-serial lexical scanner: numbers, identifiers, keywords and
// booleans, reported with start position and length, plus error records.
// ----------------------------------------------------------------------------
module source_char_tokenizer #(
    parameter int QUEUE_DEPTH = sct_pkg::FIFO_DEPTH
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  sct_pkg::in_word_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output sct_pkg::out_word_t m_data
);
    import sct_pkg::*;

    logic   fifo_full;
    logic   fifo_not_empty;
    logic   push;
    logic   pop;
    entry_t push_entry;
    entry_t head;

    sct_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .fifo_full  (fifo_full),
        .push       (push),
        .push_entry (push_entry)
    );

    sct_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .full       (fifo_full),
        .not_empty  (fifo_not_empty)
    );

    sct_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .head      (head),
        .not_empty (fifo_not_empty),
        .pop       (pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

// ----- sv/sct_front.sv -----
// ----------------------------------------------------------------------------
// sct_front
// Accepts source bytes, tracks position and token state, and queues the
// token and error records that each byte closes.
// ----------------------------------------------------------------------------
module sct_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  sct_pkg::in_word_t s_data,
    input  logic              fifo_full,
    output logic              push,
    output sct_pkg::entry_t   push_entry
);
    import sct_pkg::*;

    mode_t   mode_reg, mode_next;
    logic    dot_reg, dot_next;
    pos_t    line_reg, line_next;
    pos_t    col_reg, col_next;
    pos_t    tok_line_reg, tok_line_next;
    pos_t    tok_col_reg, tok_col_next;
    len_t    count_reg, count_next;
    prefix_t prefix_reg, prefix_next;
    entry_t  entry;
    logic    accept;

    assign s_ready    = !fifo_full;
    assign accept     = s_valid && s_ready;
    assign push       = accept && entry.first.valid;
    assign push_entry = entry;

    always_comb begin
        logic [7:0] c;
        logic       taken;
        logic       open_tok;
        slot_t      res;
        c           = s_data.char_byte;
        taken       = 1'b0;
        open_tok    = 1'b0;
        res         = '0;
        entry       = '0;
        mode_next   = mode_reg;
        dot_next    = dot_reg;
        line_next   = line_reg;
        col_next    = col_reg;
        tok_line_next = tok_line_reg;
        tok_col_next  = tok_col_reg;
        count_next  = count_reg;
        prefix_next = prefix_reg;

        case (mode_reg)
            MODE_NUMBER: begin
                if (is_digit(c)) begin
                    taken = 1'b1;
                end else if (c == CH_DOT) begin
                    taken = 1'b1;
                    if (dot_reg) begin
                        entry.first = make_slot(KIND_TWODOTS, line_reg, col_reg, '0, '0);
                        mode_next   = MODE_FAILED;
                    end else begin
                        dot_next = 1'b1;
                    end
                end else begin
                    entry.first = make_slot(KIND_NUMBER, tok_line_reg, tok_col_reg,
                                            count_reg, prefix_reg);
                    mode_next   = MODE_IDLE;
                    dot_next    = 1'b0;
                end
            end
            MODE_IDENT: begin
                if (is_digit(c) || is_letter(c) || c == CH_UNDERSCORE) begin
                    taken = 1'b1;
                end else begin
                    entry.first = make_slot(KIND_IDENT, tok_line_reg, tok_col_reg,
                                            count_reg, prefix_reg);
                    mode_next   = MODE_IDLE;
                    dot_next    = 1'b0;
                end
            end
            default: begin
            end
        endcase

        if (!taken && mode_next == MODE_IDLE) begin
            if (c == CH_SPACE || c == CH_NEWLINE) begin
                open_tok = 1'b0;
            end else if (is_digit(c)) begin
                open_tok  = 1'b1;
                mode_next = MODE_NUMBER;
            end else if (is_letter(c) || c == CH_UNDERSCORE) begin
                open_tok  = 1'b1;
                mode_next = MODE_IDENT;
            end else begin
                res = make_slot(KIND_BADCHAR, line_reg, col_reg, '0, '0);
                if (!entry.first.valid) begin
                    entry.first = res;
                end else begin
                    entry.second = res;
                end
                mode_next = MODE_FAILED;
            end
        end

        if (open_tok) begin
            dot_next      = 1'b0;
            tok_line_next = line_reg;
            tok_col_next  = col_reg;
            count_next    = '0;
            prefix_next   = '0;
        end

        // Taken bytes other than a second dot extend the open token.
        if (open_tok || (taken && mode_next != MODE_FAILED)) begin
            if (count_next < len_t'(PREFIX_BYTES)) begin
                prefix_next[8*count_next[2:0] +: 8] = c;
            end
            if (count_next != LEN_MAX) begin
                count_next = count_next + len_t'(1);
            end
        end

        if (c == CH_NEWLINE) begin
            if (line_reg != POS_MAX) begin
                line_next = line_reg + POS_ONE;
            end
            col_next = POS_ONE;
        end else if (col_reg != POS_MAX) begin
            col_next = col_reg + POS_ONE;
        end

        if (s_data.end_of_input) begin
            if (mode_next == MODE_NUMBER || mode_next == MODE_IDENT) begin
                res = make_slot((mode_next == MODE_NUMBER) ? KIND_NUMBER : KIND_IDENT,
                                tok_line_next, tok_col_next, count_next, prefix_next);
                if (!entry.first.valid) begin
                    entry.first = res;
                end else begin
                    entry.second = res;
                end
            end
            mode_next     = MODE_IDLE;
            dot_next      = 1'b0;
            line_next     = POS_ONE;
            col_next      = POS_ONE;
            tok_line_next = POS_ONE;
            tok_col_next  = POS_ONE;
            count_next    = '0;
            prefix_next   = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= MODE_IDLE;
            dot_reg      <= 1'b0;
            line_reg     <= POS_ONE;
            col_reg      <= POS_ONE;
            tok_line_reg <= POS_ONE;
            tok_col_reg  <= POS_ONE;
            count_reg    <= '0;
            prefix_reg   <= '0;
        end else if (accept) begin
            mode_reg     <= mode_next;
            dot_reg      <= dot_next;
            line_reg     <= line_next;
            col_reg      <= col_next;
            tok_line_reg <= tok_line_next;
            tok_col_reg  <= tok_col_next;
            count_reg    <= count_next;
            prefix_reg   <= prefix_next;
        end
    end

endmodule

// ----- sv/sct_fifo.sv -----
// ----------------------------------------------------------------------------
// sct_fifo
// Short queue of result records between the scanner and the output stage.
// ----------------------------------------------------------------------------
module sct_fifo #(
    parameter int DEPTH = sct_pkg::FIFO_DEPTH
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  sct_pkg::entry_t push_entry,
    input  logic            pop,
    output sct_pkg::entry_t head,
    output logic            full,
    output logic            not_empty
);
    import sct_pkg::*;

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    entry_t                mem [DEPTH];
    logic [PTR_BITS-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0]   count_reg, count_next;

    assign head      = mem[rd_ptr_reg];
    assign full      = (count_reg == CNT_BITS'(DEPTH));
    assign not_empty = (count_reg != '0);

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0
                                                               : wr_ptr_reg + PTR_BITS'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0
                                                               : rd_ptr_reg + PTR_BITS'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CNT_BITS'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_BITS'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- sv/sct_back.sv -----
// ----------------------------------------------------------------------------
// sct_back
// Drains queued records one result per cycle while m_ready allows,
// resolves keywords and holds each result word in the output register.
// ----------------------------------------------------------------------------
module sct_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  sct_pkg::entry_t    head,
    input  logic               not_empty,
    output logic               pop,
    output logic               m_valid,
    input  logic               m_ready,
    output sct_pkg::out_word_t m_data
);
    import sct_pkg::*;

    logic      phase_reg, phase_next;
    logic      m_valid_reg, m_valid_next;
    out_word_t m_data_reg, m_data_next;
    logic      load;
    logic      last;
    slot_t     sel;
    kind_t     kind;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        load = not_empty && (!m_valid_reg || m_ready);
        sel  = phase_reg ? head.second : head.first;
        last = phase_reg || !head.second.valid;
        pop  = load && last;
        kind = (sel.kind == KIND_IDENT) ? word_kind(sel.length, sel.prefix) : sel.kind;

        phase_next   = phase_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (load) begin
            phase_next               = !last;
            m_valid_next             = 1'b1;
            m_data_next.token_kind   = kind;
            m_data_next.start_line   = sel.line;
            m_data_next.start_column = sel.column;
            m_data_next.token_length = sel.length;
            m_data_next.last_of_run  = last;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

endmodule

// ----- sv/sct_checker.sv -----
// ----------------------------------------------------------------------------
// sct_checker
// Port-level checks on the tokenizer's source and result channels.
// ----------------------------------------------------------------------------
module sct_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input sct_pkg::in_word_t  s_data,
    input logic               m_valid,
    input logic               m_ready,
    input sct_pkg::out_word_t m_data
);
    import sct_pkg::*;

    logic is_error;
    assign is_error = (m_data.token_kind == KIND_BADCHAR) ||
                      (m_data.token_kind == KIND_TWODOTS);

    // A stalled source word must hold.
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_data))
        else $error("source word changed while stalled");

    // A stalled result word must hold.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_error_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && is_error |-> m_data.token_length == '0)
        else $error("error result with nonzero length");

    a_token_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !is_error |-> m_data.token_length != '0 &&
                                 m_data.start_line != '0 && m_data.start_column != '0)
        else $error("token result with empty length or zero position");

endmodule

bind source_char_tokenizer sct_checker u_sct_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
